[rtl/bcsc_pkg.sv]
// Battery charge session control: shared types, codes and constants.
// No dependencies; used by every other file of the block.
package bcsc_pkg;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_START   = 2'd1,
        CMD_STOP    = 2'd2,
        CMD_REFRESH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_TARGET_LEVEL   = 2'd0,
        REG_CHARGE_CURRENT = 2'd1,
        REG_END_STABLE     = 2'd2,
        REG_REFRESH        = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    localparam logic [17:0]        START_MIN_GAP_MV      = 18'd200;
    localparam logic signed [16:0] END_MAX_GAP_MV        = 17'sd60;
    localparam logic signed [15:0] END_MAX_CURRENT_MA    = 16'sd200;
    localparam logic [12:0]        MIN_CHARGE_CURRENT_MA = 13'd128;
    localparam logic [12:0]        MIN_CELL_LIMIT_MV     = 13'd4100;

    localparam logic [2:0]  RST_TARGET_LEVEL   = 3'd2;
    localparam logic [12:0] RST_CHARGE_CURRENT = 13'd4992;
    localparam logic [15:0] RST_END_STABLE     = 16'd1000;
    localparam logic [15:0] RST_REFRESH        = 16'd6000;

    typedef struct packed {
        logic               adapter_on;
        logic               battery_on;
        logic               fault_flag;
        logic [15:0]        pack_voltage_mv;
        logic signed [15:0] pack_current_ma;
        logic [3:0]         cell_count;
        logic [12:0]        cell_limit_mv;
    } tick_t;

    typedef struct packed {
        logic        charging;
        logic        charging_changed;
        logic [1:0]  command;
        logic [15:0] command_voltage_mv;
        logic [12:0] command_current_ma;
    } result_t;

    typedef struct packed {
        logic [2:0]  target_level;
        logic [12:0] charge_current_ma;
        logic [15:0] end_stable_ticks;
        logic [15:0] refresh_ticks;
    } cfg_t;

    typedef struct packed {
        logic        active;
        logic [15:0] end_counter;
        logic [15:0] refresh_counter;
        logic [15:0] programmed_end_mv;
    } state_t;

    // per-cell target voltage by level; levels 6 and above use the 100% value
    function automatic logic [12:0] cell_target_mv(input logic [2:0] level);
        logic [12:0] mv;
        case (level)
            3'd0:    mv = 13'd3851;
            3'd1:    mv = 13'd3890;
            3'd2:    mv = 13'd3934;
            3'd3:    mv = 13'd3987;
            3'd4:    mv = 13'd4035;
            3'd5:    mv = 13'd4081;
            default: mv = 13'd4200;
        endcase
        return mv;
    endfunction

endpackage

[rtl/bcsc_if.sv]
// Valid/ready channel interfaces for tick items and result items.
// Depends on bcsc_pkg for the payload structs.
interface bcsc_tick_if;
    logic            valid;
    logic            ready;
    bcsc_pkg::tick_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bcsc_result_if;
    logic              valid;
    logic              ready;
    bcsc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/battery_charge_session_control_top.sv]
// Battery charge session control, top level: config registers, tick and result stages.
// Depends on bcsc_pkg, bcsc_if, bcsc_target and bcsc_step.
//
// Usage: one tick item enters on the tick channel (valid/ready); exactly one
// result item leaves on the result channel for each tick, in order.
// A tick is registered in the tick register on its transfer, evaluated against
// the session state, and its result registered in the result register once that
// is free. One tick per cycle is sustained while result.ready stays high; the
// session state updates as each result is registered, so a tick directly behind
// another sees its effect.
// If the receiver holds result.ready low, the result register holds its item and
// the tick register holds one more; tick.ready then drops until the result moves.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect on the next
// edge; the user must make them only while no tick is in flight (not enforced).
// Reset: configuration returns to its defaults (level 2, 4992 mA, 1000 end
// ticks, 6000 refresh ticks), the session is idle, counters and the programmed
// end voltage are zero, and both stages are empty.
module battery_charge_session_control_top #(
    parameter int VOLTAGE_ALIGN_BITS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [bcsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    bcsc_tick_if.sink                       tick,
    bcsc_result_if.source                   result
);

    bcsc_pkg::cfg_t    cfg_reg;
    bcsc_pkg::state_t  state_reg;
    bcsc_pkg::state_t  state_next;
    bcsc_pkg::tick_t   tick_reg;
    logic              tick_valid_reg;
    bcsc_pkg::result_t result_reg;
    bcsc_pkg::result_t result_next;
    logic              result_valid_reg;
    logic              out_free;
    logic              advance;
    logic [15:0]       target_mv;

    assign out_free     = !result_valid_reg || result.ready;
    assign advance      = tick_valid_reg && out_free;
    assign tick.ready   = !tick_valid_reg || out_free;
    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level      <= bcsc_pkg::RST_TARGET_LEVEL;
            cfg_reg.charge_current_ma <= bcsc_pkg::RST_CHARGE_CURRENT;
            cfg_reg.end_stable_ticks  <= bcsc_pkg::RST_END_STABLE;
            cfg_reg.refresh_ticks     <= bcsc_pkg::RST_REFRESH;
        end
        else if (cfg_we)
        begin
            case (bcsc_pkg::cfg_index_t'(cfg_index))
                bcsc_pkg::REG_TARGET_LEVEL:   cfg_reg.target_level      <= cfg_wdata[2:0];
                bcsc_pkg::REG_CHARGE_CURRENT: cfg_reg.charge_current_ma <= cfg_wdata[12:0];
                bcsc_pkg::REG_END_STABLE:     cfg_reg.end_stable_ticks  <= cfg_wdata[15:0];
                bcsc_pkg::REG_REFRESH:        cfg_reg.refresh_ticks     <= cfg_wdata[15:0];
                default:                      cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (tick.ready)
            begin
                tick_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            tick_reg <= tick.data;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    bcsc_target #(
        .VOLTAGE_ALIGN_BITS (VOLTAGE_ALIGN_BITS)
    ) u_target (
        .target_level  (cfg_reg.target_level),
        .cell_count    (tick_reg.cell_count),
        .cell_limit_mv (tick_reg.cell_limit_mv),
        .target_mv     (target_mv)
    );

    bcsc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .tick       (tick_reg),
        .target_mv  (target_mv),
        .state_next (state_next),
        .result     (result_next)
    );

endmodule

[rtl/bcsc_target.sv]
// Start target voltage: per-cell table value times cell count, clamped, step-aligned.
// Depends on bcsc_pkg.
module bcsc_target #(
    parameter int VOLTAGE_ALIGN_BITS = 4
) (
    input  logic [2:0]  target_level,
    input  logic [3:0]  cell_count,
    input  logic [12:0] cell_limit_mv,
    output logic [15:0] target_mv
);

    localparam logic [15:0] ALIGN_MASK = 16'(16'hFFFF << VOLTAGE_ALIGN_BITS);

    logic [12:0] limit_eff;
    logic [16:0] table_prod;
    logic [16:0] limit_prod;
    logic [16:0] min_prod;
    logic [15:0] sat_prod;

    always_comb
    begin
        limit_eff  = (cell_limit_mv > bcsc_pkg::MIN_CELL_LIMIT_MV)
                     ? cell_limit_mv : bcsc_pkg::MIN_CELL_LIMIT_MV;
        table_prod = 17'(bcsc_pkg::cell_target_mv(target_level)) * 17'(cell_count);
        limit_prod = 17'(limit_eff) * 17'(cell_count);
        min_prod   = (table_prod > limit_prod) ? limit_prod : table_prod;
        sat_prod   = min_prod[16] ? 16'hFFFF : min_prod[15:0];
        target_mv  = sat_prod & ALIGN_MASK;
    end

endmodule

[rtl/bcsc_step.sv]
// One tick of the session controller: next state and result from state and tick.
// Depends on bcsc_pkg; the start target comes from bcsc_target.
module bcsc_step (
    input  bcsc_pkg::cfg_t    cfg,
    input  bcsc_pkg::state_t  state,
    input  bcsc_pkg::tick_t   tick,
    input  logic [15:0]       target_mv,
    output bcsc_pkg::state_t  state_next,
    output bcsc_pkg::result_t result
);

    logic               current_ok;
    logic               fault;
    logic signed [16:0] end_gap;
    logic               end_cond;
    logic [15:0]        end_cnt_inc;
    logic [15:0]        period;
    logic [16:0]        refresh_inc;
    logic signed [17:0] start_gap;
    bcsc_pkg::cmd_t     cmd;

    always_comb
    begin
        current_ok  = cfg.charge_current_ma >= bcsc_pkg::MIN_CHARGE_CURRENT_MA;
        fault       = tick.battery_on & tick.fault_flag;
        end_gap     = $signed({1'b0, state.programmed_end_mv})
                      - $signed({1'b0, tick.pack_voltage_mv});
        end_cond    = (end_gap < bcsc_pkg::END_MAX_GAP_MV)
                      && (tick.pack_current_ma < bcsc_pkg::END_MAX_CURRENT_MA);
        end_cnt_inc = (&state.end_counter) ? state.end_counter : state.end_counter + 16'd1;
        period      = (cfg.refresh_ticks == 16'd0) ? 16'd1 : cfg.refresh_ticks;
        refresh_inc = {1'b0, state.refresh_counter} + 17'd1;
        start_gap   = $signed({2'b00, target_mv}) - $signed({2'b00, tick.pack_voltage_mv});

        state_next                = state;
        cmd                       = bcsc_pkg::CMD_NONE;
        result.command_voltage_mv = 16'd0;
        result.command_current_ma = 13'd0;

        if (state.active)
        begin
            if (!tick.adapter_on)
            begin
                state_next.active = 1'b0;
            end
            else if (!tick.battery_on || !current_ok || fault)
            begin
                state_next.active = 1'b0;
                cmd               = bcsc_pkg::CMD_STOP;
            end
            else if (end_cond)
            begin
                state_next.end_counter = end_cnt_inc;
                if (end_cnt_inc >= cfg.end_stable_ticks)
                begin
                    state_next.active = 1'b0;
                    cmd               = bcsc_pkg::CMD_STOP;
                end
            end
            else
            begin
                state_next.end_counter = 16'd0;
                if (refresh_inc >= {1'b0, period})
                begin
                    state_next.refresh_counter = 16'd0;
                    cmd                        = bcsc_pkg::CMD_REFRESH;
                    result.command_current_ma  = cfg.charge_current_ma;
                end
                else
                begin
                    state_next.refresh_counter = refresh_inc[15:0];
                end
            end
        end
        else if (tick.adapter_on && tick.battery_on && current_ok && !fault)
        begin
            if (start_gap > $signed(bcsc_pkg::START_MIN_GAP_MV))
            begin
                state_next.programmed_end_mv = target_mv;
                state_next.refresh_counter   = 16'd0;
                state_next.end_counter       = 16'd0;
                state_next.active            = 1'b1;
                cmd                          = bcsc_pkg::CMD_START;
                result.command_voltage_mv    = target_mv;
                result.command_current_ma    = cfg.charge_current_ma;
            end
        end

        result.charging         = state_next.active;
        result.charging_changed = state_next.active ^ state.active;
        result.command          = cmd;
    end

endmodule
